>>> src/kpsc_pkg.sv
// Package for the keypad stepper controller: types, codes and pattern tables.
package kpsc_pkg;

  typedef enum logic [1:0] {
    MODE_SCAN   = 2'd0,
    MODE_SETTLE = 2'd1,
    MODE_RIGHT  = 2'd2,
    MODE_LEFT   = 2'd3
  } mode_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_SPEED_STEP    = 2'd0;
  localparam logic [1:0] CFG_SPEED_FLOOR   = 2'd1;
  localparam logic [1:0] CFG_SPEED_CEILING = 2'd2;
  localparam logic [1:0] CFG_SETTLE_TICKS  = 2'd3;

  localparam logic [4:0] RST_SPEED_STEP    = 5'd5;
  localparam logic [6:0] RST_SPEED_FLOOR   = 7'd5;
  localparam logic [6:0] RST_SPEED_CEILING = 7'd100;
  localparam logic [6:0] RST_SETTLE_TICKS  = 7'd120;
  localparam logic [6:0] RST_SPEED         = 7'd50;
  localparam logic [3:0] RST_ROW_LATCH     = 4'd7;

  localparam logic [4:0] KEY_FASTER = 5'd2;
  localparam logic [4:0] KEY_RIGHT  = 5'd3;
  localparam logic [4:0] KEY_SLOWER = 5'd6;
  localparam logic [4:0] KEY_LEFT   = 5'd7;

  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 24;

  typedef struct packed {
    logic [4:0] speed_step;
    logic [6:0] speed_floor;
    logic [6:0] speed_ceiling;
    logic [6:0] settle_ticks;
  } cfg_t;

  typedef struct packed {
    mode_t      mode_now;
    logic [4:0] decided_key;
    logic [6:0] speed_value;
    logic [3:0] coil_pattern;
    logic [3:0] row_drive;
  } res_t;

  function automatic logic [3:0] row_pat(input logic [1:0] row);
    case (row)
      2'd0:    row_pat = 4'd7;
      2'd1:    row_pat = 4'd11;
      2'd2:    row_pat = 4'd13;
      default: row_pat = 4'd14;
    endcase
  endfunction

  function automatic logic [3:0] right_pat(input logic [1:0] ph);
    case (ph)
      2'd0:    right_pat = 4'd10;
      2'd1:    right_pat = 4'd6;
      2'd2:    right_pat = 4'd5;
      default: right_pat = 4'd9;
    endcase
  endfunction

  function automatic logic [3:0] left_pat(input logic [1:0] ph);
    case (ph)
      2'd0:    left_pat = 4'd9;
      2'd1:    left_pat = 4'd5;
      2'd2:    left_pat = 4'd6;
      default: left_pat = 4'd10;
    endcase
  endfunction

endpackage

>>> src/kpsc_cfg.sv
// Configuration register bank for the keypad stepper controller.
module kpsc_cfg (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [1:0]           wr_index,
  input  logic [7:0]           wr_data,
  output kpsc_pkg::cfg_t       cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.speed_step    <= kpsc_pkg::RST_SPEED_STEP;
      cfg.speed_floor   <= kpsc_pkg::RST_SPEED_FLOOR;
      cfg.speed_ceiling <= kpsc_pkg::RST_SPEED_CEILING;
      cfg.settle_ticks  <= kpsc_pkg::RST_SETTLE_TICKS;
    end else if (wr_en) begin
      unique case (wr_index)
        kpsc_pkg::CFG_SPEED_STEP:    cfg.speed_step    <= wr_data[4:0];
        kpsc_pkg::CFG_SPEED_FLOOR:   cfg.speed_floor   <= wr_data[6:0];
        kpsc_pkg::CFG_SPEED_CEILING: cfg.speed_ceiling <= wr_data[6:0];
        kpsc_pkg::CFG_SETTLE_TICKS:  cfg.settle_ticks  <= wr_data[6:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/kpsc_core.sv
// Scan and stepper state with the per-tick next-state and result logic.
module kpsc_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic [3:0]      column_levels,
  input  kpsc_pkg::cfg_t  cfg,
  output kpsc_pkg::res_t  res
);

  kpsc_pkg::mode_t mode_reg, mode_reg_next;
  logic [1:0] row_index, row_index_next;
  logic [4:0] key_accum, key_accum_next;
  logic [6:0] speed_reg, speed_reg_next;
  logic [1:0] phase_index, phase_index_next;
  logic [6:0] tick_count, tick_count_next;
  logic [3:0] row_latch, row_latch_next;

  logic [4:0] key_scan;
  logic       scan_end;
  logic [4:0] decided;
  logic [6:0] hold;
  logic [6:0] tick_dec;
  logic [7:0] speed_sum;
  logic signed [8:0] speed_diff;
  logic [6:0] speed_up;
  logic [6:0] speed_down;

  // last pressed column in this row wins over earlier ones
  always_comb begin
    key_scan = key_accum;
    for (int c = 0; c < 4; c++) begin
      if (!column_levels[c]) key_scan = {1'b0, row_index, 2'(c)} + 5'd1;
    end
  end

  assign scan_end   = (row_index == 2'd3);
  assign decided    = scan_end ? key_scan : 5'd0;
  assign hold       = (speed_reg == 7'd0) ? 7'd1 : speed_reg;
  assign tick_dec   = (tick_count != 7'd0) ? tick_count - 7'd1 : 7'd0;
  assign speed_sum  = {1'b0, speed_reg} + {3'b0, cfg.speed_step};
  assign speed_diff = $signed({2'b0, speed_reg}) - $signed({4'b0, cfg.speed_step});
  assign speed_up   = (speed_sum >= {1'b0, cfg.speed_ceiling}) ? cfg.speed_ceiling
                                                               : speed_sum[6:0];
  assign speed_down = (speed_diff <= $signed({2'b0, cfg.speed_floor})) ? cfg.speed_floor
                                                                      : speed_diff[6:0];

  // next mode
  always_comb begin
    mode_reg_next = mode_reg;
    unique case (mode_reg)
      kpsc_pkg::MODE_SCAN: begin
        if (scan_end) begin
          if (decided == kpsc_pkg::KEY_FASTER || decided == kpsc_pkg::KEY_SLOWER) begin
            mode_reg_next = (cfg.settle_ticks == 7'd0) ? kpsc_pkg::MODE_SCAN
                                                       : kpsc_pkg::MODE_SETTLE;
          end else if (decided == kpsc_pkg::KEY_RIGHT) begin
            mode_reg_next = kpsc_pkg::MODE_RIGHT;
          end else if (decided == kpsc_pkg::KEY_LEFT) begin
            mode_reg_next = kpsc_pkg::MODE_LEFT;
          end
        end
      end
      kpsc_pkg::MODE_SETTLE: begin
        if (tick_dec == 7'd0) mode_reg_next = kpsc_pkg::MODE_SCAN;
      end
      kpsc_pkg::MODE_RIGHT, kpsc_pkg::MODE_LEFT: begin
        if (tick_dec == 7'd0 && phase_index == 2'd3) mode_reg_next = kpsc_pkg::MODE_SCAN;
      end
      default: mode_reg_next = kpsc_pkg::MODE_SCAN;
    endcase
  end

  // datapath and result
  always_comb begin
    row_index_next   = row_index;
    key_accum_next   = key_accum;
    speed_reg_next   = speed_reg;
    phase_index_next = phase_index;
    tick_count_next  = tick_count;
    row_latch_next   = row_latch;
    res.coil_pattern = 4'd0;
    unique case (mode_reg)
      kpsc_pkg::MODE_SCAN: begin
        row_latch_next = kpsc_pkg::row_pat(row_index);
        if (scan_end) begin
          key_accum_next = 5'd0;
          row_index_next = 2'd0;
          if (decided == kpsc_pkg::KEY_FASTER || decided == kpsc_pkg::KEY_SLOWER) begin
            speed_reg_next = (decided == kpsc_pkg::KEY_FASTER) ? speed_up : speed_down;
            if (cfg.settle_ticks != 7'd0) tick_count_next = cfg.settle_ticks;
          end else if (decided == kpsc_pkg::KEY_RIGHT || decided == kpsc_pkg::KEY_LEFT) begin
            phase_index_next = 2'd0;
            tick_count_next  = hold;
          end
        end else begin
          key_accum_next = key_scan;
          row_index_next = row_index + 2'd1;
        end
      end
      kpsc_pkg::MODE_SETTLE: begin
        tick_count_next = tick_dec;
      end
      kpsc_pkg::MODE_RIGHT, kpsc_pkg::MODE_LEFT: begin
        res.coil_pattern = (mode_reg == kpsc_pkg::MODE_RIGHT) ?
                           kpsc_pkg::right_pat(phase_index) : kpsc_pkg::left_pat(phase_index);
        tick_count_next = tick_dec;
        if (tick_dec == 7'd0) begin
          if (phase_index == 2'd3) begin
            phase_index_next = 2'd0;
            row_index_next   = 2'd0;
            key_accum_next   = 5'd0;
          end else begin
            phase_index_next = phase_index + 2'd1;
            tick_count_next  = hold;
          end
        end
      end
      default: ;
    endcase
    res.row_drive   = row_latch_next;
    res.speed_value = speed_reg_next;
    res.decided_key = (mode_reg == kpsc_pkg::MODE_SCAN) ? decided : 5'd0;
    res.mode_now    = mode_reg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg    <= kpsc_pkg::MODE_SCAN;
      row_index   <= 2'd0;
      key_accum   <= 5'd0;
      speed_reg   <= kpsc_pkg::RST_SPEED;
      phase_index <= 2'd0;
      tick_count  <= 7'd0;
      row_latch   <= kpsc_pkg::RST_ROW_LATCH;
    end else if (step) begin
      mode_reg    <= mode_reg_next;
      row_index   <= row_index_next;
      key_accum   <= key_accum_next;
      speed_reg   <= speed_reg_next;
      phase_index <= phase_index_next;
      tick_count  <= tick_count_next;
      row_latch   <= row_latch_next;
    end
  end

endmodule

>>> src/keypad_stepper_controller_unit.sv
// The result item for an accepted tick item is registered into the output register as that tick item is accepted.
// Throughput: one tick item per clock; the output register frees as its item is taken,
// so input ready follows the output side only when that register is full.
// Reset (rst, synchronous, active high): scanning at row 0, speed 50, coils off,
// configuration registers to their defaults, output register empty.
// Configuration writes complete in the cycle they are offered.
module keypad_stepper_controller_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [kpsc_pkg::IN_TDATA_W-1:0]      s_tdata,   // [3:0] column_levels
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [kpsc_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [3:0] row_drive, [7:4] coil_pattern,
                                                          // [14:8] speed_value,
                                                          // [19:15] decided_key,
                                                          // [21:20] mode_now
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [1:0]                           cfg_index,
  input  logic [7:0]                           cfg_data
);

  kpsc_pkg::cfg_t cfg;
  kpsc_pkg::res_t res;
  logic           in_fire;
  logic [21:0]    out_data;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign in_fire   = s_tvalid && s_tready;

  kpsc_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  kpsc_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (in_fire),
    .column_levels (s_tdata[3:0]),
    .cfg           (cfg),
    .res           (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data <= res;
    end
  end

  assign m_tdata = {2'b00, out_data};

  // coils are driven only while turning
  a_coil_off: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[21] |-> m_tdata[7:4] == 4'd0)
    else $error("coil pattern active outside turning");

  // a key is reported only by a scanning tick
  a_key_scan: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[19:15] != 5'd0 |-> m_tdata[21:20] == kpsc_pkg::MODE_SCAN)
    else $error("key decided outside scanning");

  // exactly one row is driven low
  a_one_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $countones(m_tdata[3:0]) == 3)
    else $error("row drive not one-cold");

  // a result taken with no new item leaves the output register empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !s_tvalid |=> !m_tvalid)
    else $error("stale result after drain");

endmodule
